>>> sv/mgr_pkg.sv
// Shared constants and types for the median gap rate estimator.
// Used by mgr_div and median_gap_rate_estimator; depends on nothing else.

package mgr_pkg;

    // Window and field widths.
    localparam int WINDOW    = 32;
    localparam int IDX_BITS  = $clog2(WINDOW);
    localparam int CNT_BITS  = $clog2(WINDOW + 1);
    localparam int GAP_BITS  = 32;
    localparam int TS_BITS   = 63;
    localparam int RATE_BITS = 40;
    localparam int MED_BITS  = GAP_BITS + 1;

    // Dividend of the rate: two times 10^12 millihertz-nanoseconds.
    localparam int NUM_BITS = 41;
    localparam logic [NUM_BITS-1:0] TWO_TERA_MHZ = 41'd2000000000000;

    // Largest gap that the ring can hold.
    localparam logic [GAP_BITS-1:0] GAP_MAX = '1;

    typedef logic [GAP_BITS-1:0] t_gap;
    typedef logic [MED_BITS-1:0] t_med;

endpackage

>>> sv/mgr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; read-during-write to one address returns the old data.

module mgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> sv/mgr_div.sv
// Serial restoring divider: computes the constant TWO_TERA_MHZ over a divisor.
// Depends on mgr_pkg; takes one quotient bit per cycle.

module mgr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  mgr_pkg::t_med                i_divisor,
    output logic                         o_done,
    output logic [mgr_pkg::NUM_BITS-1:0] o_quotient
);

    localparam int STEP_BITS = $clog2(mgr_pkg::NUM_BITS + 1);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [STEP_BITS-1:0]         r_step, n_step;
    logic [mgr_pkg::NUM_BITS-1:0] r_num, n_num;
    mgr_pkg::t_med                r_rem, n_rem;
    mgr_pkg::t_med                r_den, n_den;

    logic [mgr_pkg::MED_BITS:0]   shifted;
    logic                         ge;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign shifted = {r_rem, r_num[mgr_pkg::NUM_BITS-1]};
    assign ge      = shifted >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_BITS'(mgr_pkg::NUM_BITS);
            n_num  = mgr_pkg::TWO_TERA_MHZ;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            // The quotient bit fills the place that the dividend bit left.
            n_num = {r_num[mgr_pkg::NUM_BITS-2:0], ge};
            if (ge) begin
                n_rem = mgr_pkg::MED_BITS'(shifted - {1'b0, r_den});
            end else begin
                n_rem = shifted[mgr_pkg::MED_BITS-1:0];
            end
            n_step = r_step - 1'b1;
            if (r_step == STEP_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

>>> sv/median_gap_rate_estimator.sv
// Median gap rate estimator: top level with the sequencer and both gap memories.
// Depends on mgr_pkg, mgr_ram and mgr_div.
//
// Usage:
// The input channel (i_in_valid / o_in_ready) carries a 63-bit source timestamp in
// nanoseconds and a restart flag. Every input transfer yields exactly one result
// on the output channel (o_out_valid / i_out_ready): the rate in millihertz, a
// valid flag and twice the median gap of the last 32 positive gaps.
// A restart, a stored timestamp of zero or a gap that is not positive goes from the
// evaluation straight to the hand-off. A positive gap is evaluated, updates the ring,
// goes through a delete sweep (full window only) and an insert sweep over the sorted
// gap memory (one read port, one entry a cycle), a median read, a serial divide (41
// quotient bits and a done flag) and the hand-off. One item is processed at a time;
// o_in_ready is high only while the sequencer is idle.
// The result sits in an output register. While it waits for the receiver the
// next item is accepted and worked on; it stalls only at its own hand-off.
// Reset clears the window, the stored timestamp and the reported rate. The gap
// memories are not cleared; only entries written since the last emptying are read.

module median_gap_rate_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mgr_pkg::TS_BITS-1:0]   i_source_timestamp,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mgr_pkg::RATE_BITS-1:0] o_rate_millihz,
    output logic                          o_rate_valid,
    output logic [mgr_pkg::MED_BITS-1:0]  o_median_gap_twice
);

    localparam int IDX = mgr_pkg::IDX_BITS;
    localparam int CNT = mgr_pkg::CNT_BITS;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EVAL = 9'b000000010,
        S_RING = 9'b000000100,
        S_DEL  = 9'b000001000,
        S_INS  = 9'b000010000,
        S_INS0 = 9'b000100000,
        S_MED  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state                         r_state, n_state;
    logic [IDX-1:0]                 r_wp, n_wp;
    logic [CNT-1:0]                 r_cnt, n_cnt;
    logic [mgr_pkg::TS_BITS-1:0]    r_last, n_last;
    logic [mgr_pkg::RATE_BITS-1:0]  r_rate, n_rate;
    mgr_pkg::t_med                  r_med, n_med;
    logic                           r_pv, n_pv;
    logic                           r_iss, n_iss;
    logic                           r_found, n_found;
    logic                           r_out_valid, n_out_valid;

    logic [mgr_pkg::TS_BITS-1:0]    r_ts, n_ts;
    logic                           r_restart, n_restart;
    mgr_pkg::t_gap                  r_gap, n_gap;
    mgr_pkg::t_gap                  r_old, n_old;
    mgr_pkg::t_gap                  r_lo, n_lo;
    logic [CNT-1:0]                 r_ridx, n_ridx;
    logic [IDX-1:0]                 r_pidx, n_pidx;
    logic [1:0]                     r_mstep, n_mstep;
    logic [mgr_pkg::RATE_BITS-1:0]  r_out_rate, n_out_rate;
    logic                           r_out_rv, n_out_rv;
    mgr_pkg::t_med                  r_out_med, n_out_med;

    // Memory and divider connections.
    logic                           ring_we;
    mgr_pkg::t_gap                  ring_rdata;
    logic                           sort_we;
    logic [IDX-1:0]                 sort_waddr;
    mgr_pkg::t_gap                  sort_wdata;
    logic [IDX-1:0]                 sort_raddr;
    mgr_pkg::t_gap                  sort_rdata;
    logic                           div_start;
    logic                           div_done;
    logic [mgr_pkg::NUM_BITS-1:0]   div_quo;

    logic [mgr_pkg::TS_BITS-1:0]    ts_diff;
    mgr_pkg::t_gap                  gap_sat;
    logic [CNT-1:0]                 cnt_less1;
    logic [IDX-1:0]                 med_lo_addr;
    logic [IDX-1:0]                 med_hi_addr;
    mgr_pkg::t_med                  med_sum;

    // Ring of gaps in arrival order; the entry at the write position is the oldest.
    mgr_ram #(
        .WIDTH (mgr_pkg::GAP_BITS),
        .DEPTH (mgr_pkg::WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (r_gap),
        .i_raddr (r_wp),
        .o_rdata (ring_rdata)
    );

    // The same gaps kept in ascending order, entries 0 to count-1.
    mgr_ram #(
        .WIDTH (mgr_pkg::GAP_BITS),
        .DEPTH (mgr_pkg::WINDOW)
    ) u_sorted (
        .i_clk   (i_clk),
        .i_we    (sort_we),
        .i_waddr (sort_waddr),
        .i_wdata (sort_wdata),
        .i_raddr (sort_raddr),
        .o_rdata (sort_rdata)
    );

    // Serial divider for the rate.
    mgr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (med_sum),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Gap to the previous timestamp, saturated to the gap width.
    assign ts_diff = r_ts - r_last;
    assign gap_sat = (|ts_diff[mgr_pkg::TS_BITS-1:mgr_pkg::GAP_BITS]) ?
                     mgr_pkg::GAP_MAX : ts_diff[mgr_pkg::GAP_BITS-1:0];

    // Middle entries of the sorted list; both are the same entry for an odd count.
    assign cnt_less1   = r_cnt - 1'b1;
    assign med_lo_addr = cnt_less1[IDX:1];
    assign med_hi_addr = r_cnt[IDX:1];
    assign med_sum     = {1'b0, r_lo} + {1'b0, sort_rdata};

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_rate      = r_rate;
        n_med       = r_med;
        n_pv        = 1'b0;
        n_iss       = r_iss;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_ts        = r_ts;
        n_restart   = r_restart;
        n_gap       = r_gap;
        n_old       = r_old;
        n_lo        = r_lo;
        n_ridx      = r_ridx;
        n_pidx      = r_ridx[IDX-1:0];
        n_mstep     = r_mstep;
        n_out_rate  = r_out_rate;
        n_out_rv    = r_out_rv;
        n_out_med   = r_out_med;
        ring_we     = 1'b0;
        sort_we     = 1'b0;
        sort_waddr  = '0;
        sort_wdata  = r_gap;
        sort_raddr  = r_ridx[IDX-1:0];
        div_start   = 1'b0;

        // A waiting result leaves on its transfer.
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ts      = i_source_timestamp;
                    n_restart = i_restart;
                    n_state   = S_EVAL;
                end
            end

            S_EVAL: begin
                if (r_restart || (r_last == '0)) begin
                    // Empty the window and only record the timestamp.
                    n_cnt   = '0;
                    n_wp    = '0;
                    n_rate  = '0;
                    n_med   = '0;
                    n_last  = r_ts;
                    n_state = S_OUT;
                end else if (r_ts <= r_last) begin
                    n_last  = r_ts;
                    n_state = S_OUT;
                end else begin
                    n_last  = r_ts;
                    n_gap   = gap_sat;
                    n_state = S_RING;
                end
            end

            S_RING: begin
                // The ring read of the write position is back: that is the oldest gap.
                ring_we = 1'b1;
                n_old   = ring_rdata;
                n_wp    = (r_wp == IDX'(mgr_pkg::WINDOW - 1)) ? '0 : r_wp + 1'b1;
                if (r_cnt == CNT'(mgr_pkg::WINDOW)) begin
                    n_ridx  = '0;
                    n_found = 1'b0;
                    n_state = S_DEL;
                end else if (r_cnt == '0) begin
                    n_state = S_INS0;
                end else begin
                    n_ridx  = cnt_less1;
                    n_iss   = 1'b1;
                    n_state = S_INS;
                end
            end

            S_DEL: begin
                // Sweep upward; after the oldest gap is found, shift each entry down.
                if (r_ridx < r_cnt) begin
                    n_ridx = r_ridx + 1'b1;
                    n_pv   = 1'b1;
                end
                if (r_pv) begin
                    if (r_found) begin
                        sort_we    = 1'b1;
                        sort_waddr = r_pidx - 1'b1;
                        sort_wdata = sort_rdata;
                    end else if (sort_rdata == r_old) begin
                        n_found = 1'b1;
                    end
                    if (r_pidx == cnt_less1[IDX-1:0]) begin
                        n_cnt   = cnt_less1;
                        n_ridx  = r_cnt - CNT'(2);
                        n_iss   = 1'b1;
                        n_pv    = 1'b0;
                        n_state = S_INS;
                    end
                end
            end

            S_INS: begin
                // Sweep downward, moving larger entries up until the new gap fits.
                if (r_iss) begin
                    n_pv   = 1'b1;
                    n_pidx = r_ridx[IDX-1:0];
                    if (r_ridx == '0) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ridx = r_ridx - 1'b1;
                    end
                end
                if (r_pv) begin
                    sort_we    = 1'b1;
                    sort_waddr = r_pidx + 1'b1;
                    if (sort_rdata > r_gap) begin
                        sort_wdata = sort_rdata;
                        if (r_pidx == '0) begin
                            n_pv    = 1'b0;
                            n_iss   = 1'b0;
                            n_state = S_INS0;
                        end
                    end else begin
                        sort_wdata = r_gap;
                        n_cnt      = r_cnt + 1'b1;
                        n_pv       = 1'b0;
                        n_iss      = 1'b0;
                        n_mstep    = '0;
                        n_state    = S_MED;
                    end
                end
            end

            S_INS0: begin
                // The new gap is the smallest.
                sort_we    = 1'b1;
                sort_waddr = '0;
                sort_wdata = r_gap;
                n_cnt      = r_cnt + 1'b1;
                n_mstep    = '0;
                n_state    = S_MED;
            end

            S_MED: begin
                // Read the lower then the upper middle entry and add them.
                n_mstep    = r_mstep + 1'b1;
                sort_raddr = (r_mstep == 2'd0) ? med_lo_addr : med_hi_addr;
                if (r_mstep == 2'd1) begin
                    n_lo = sort_rdata;
                end
                if (r_mstep == 2'd2) begin
                    n_med     = med_sum;
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end

            S_DIV: begin
                if (div_done) begin
                    n_rate  = div_quo[mgr_pkg::RATE_BITS-1:0];
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_rate  = r_rate;
                    n_out_rv    = (r_cnt != '0);
                    n_out_med   = r_med;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_last      <= '0;
            r_rate      <= '0;
            r_med       <= '0;
            r_pv        <= 1'b0;
            r_iss       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_rate      <= n_rate;
            r_med       <= n_med;
            r_pv        <= n_pv;
            r_iss       <= n_iss;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_ts       <= n_ts;
        r_restart  <= n_restart;
        r_gap      <= n_gap;
        r_old      <= n_old;
        r_lo       <= n_lo;
        r_ridx     <= n_ridx;
        r_pidx     <= n_pidx;
        r_mstep    <= n_mstep;
        r_out_rate <= n_out_rate;
        r_out_rv   <= n_out_rv;
        r_out_med  <= n_out_med;
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_rate_millihz     = r_out_rate;
    assign o_rate_valid       = r_out_rv;
    assign o_median_gap_twice = r_out_med;

endmodule

>>> tb/sv/mgr_rate_checker.sv
// Checker for the median gap rate estimator: it watches both channels, predicts
// every result and compares each output transfer against the oldest prediction.
// Depends on mgr_pkg for widths, gap types and the rate dividend.

module mgr_rate_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [mgr_pkg::TS_BITS-1:0]   i_source_timestamp,
    input  logic                          i_restart,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [mgr_pkg::RATE_BITS-1:0] i_rate_millihz,
    input  logic                          i_rate_valid,
    input  logic [mgr_pkg::MED_BITS-1:0]  i_median_gap_twice,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_results_checked,
    output int                            o_full_window_results
);

    typedef struct packed {
        logic [mgr_pkg::RATE_BITS-1:0] rate;
        logic                          valid;
        mgr_pkg::t_med                 med_twice;
    } t_rate_result;

    // Predicted state of the estimator.
    mgr_pkg::t_gap                 gap_ring [mgr_pkg::WINDOW];
    logic [mgr_pkg::IDX_BITS-1:0]  wr_pos;
    logic [mgr_pkg::CNT_BITS-1:0]  gap_cnt;
    logic [63:0]                   prev_ts;
    logic [mgr_pkg::RATE_BITS-1:0] cur_rate;
    mgr_pkg::t_med                 cur_med_twice;

    t_rate_result rate_expected_q [$];
    int fails = 0;
    int checked = 0;
    int full_window = 0;

    // Twice the median of the first n ring entries, found by sorting a copy.
    function automatic mgr_pkg::t_med twice_median(input int n);
        mgr_pkg::t_gap sorted [mgr_pkg::WINDOW];
        mgr_pkg::t_gap key;
        int i;
        int j;
        for (i = 0; i < n; i++) sorted[i] = gap_ring[i];
        for (i = 1; i < n; i++) begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        if (n % 2 == 0) begin
            return mgr_pkg::t_med'(sorted[n / 2 - 1]) + mgr_pkg::t_med'(sorted[n / 2]);
        end
        return {sorted[n / 2], 1'b0};
    endfunction

    // Advances the predicted state by one input transfer and returns its result.
    function automatic t_rate_result predict_rate(
        input logic [mgr_pkg::TS_BITS-1:0] ts,
        input logic restart
    );
        logic [63:0] ts_ext;
        logic [63:0] gap;
        logic [63:0] divisor;
        t_rate_result res;
        ts_ext = 64'(ts);
        if (restart || prev_ts == 64'd0) begin
            // Restart or empty history: the window is emptied.
            gap_cnt = '0;
            wr_pos = '0;
            cur_rate = '0;
            cur_med_twice = '0;
            prev_ts = ts_ext;
        end else if (ts_ext <= prev_ts) begin
            // A gap that is not positive only moves the stored timestamp.
            prev_ts = ts_ext;
        end else begin
            gap = ts_ext - prev_ts;
            prev_ts = ts_ext;
            if (gap > 64'(mgr_pkg::GAP_MAX)) gap = 64'(mgr_pkg::GAP_MAX);
            gap_ring[wr_pos] = gap[mgr_pkg::GAP_BITS-1:0];
            wr_pos = wr_pos + 1'b1;
            if (gap_cnt < mgr_pkg::WINDOW) gap_cnt = gap_cnt + 1'b1;
            if (gap_cnt == mgr_pkg::WINDOW) full_window++;
            cur_med_twice = twice_median(int'(gap_cnt));
            divisor = 64'(cur_med_twice);
            cur_rate = (divisor != 64'd0)
                ? mgr_pkg::RATE_BITS'(64'(mgr_pkg::TWO_TERA_MHZ) / divisor) : '0;
        end
        res.rate = cur_rate;
        res.valid = (gap_cnt != '0);
        res.med_twice = cur_med_twice;
        return res;
    endfunction

    function automatic int field_mismatch(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Output transfers are matched before input transfers are predicted, so a
    // result never meets the prediction made in the same cycle.
    always @(posedge i_clk) begin
        t_rate_result want;
        if (!i_rst_n) begin
            wr_pos = '0;
            gap_cnt = '0;
            prev_ts = '0;
            cur_rate = '0;
            cur_med_twice = '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (rate_expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected, rate %0d median %0d",
                             $time, i_rate_millihz, i_median_gap_twice);
                    fails++;
                end else begin
                    want = rate_expected_q.pop_front();
                    checked++;
                    fails += field_mismatch("rate_millihz", 64'(want.rate),
                                            64'(i_rate_millihz));
                    fails += field_mismatch("rate_valid", 64'(want.valid),
                                            64'(i_rate_valid));
                    fails += field_mismatch("median_gap_twice", 64'(want.med_twice),
                                            64'(i_median_gap_twice));
                end
            end
            if (i_in_valid && i_in_ready) begin
                rate_expected_q.push_back(predict_rate(i_source_timestamp, i_restart));
            end
        end
        o_fail_count <= fails;
        o_pending <= rate_expected_q.size();
        o_results_checked <= checked;
        o_full_window_results <= full_window;
    end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the median gap rate estimator: clock, reset, timestamp
// stimulus, random stalls, watchdog and verdict. Depends on mgr_pkg,
// mgr_rate_checker and median_gap_rate_estimator.

module tb;

    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [63:0] TS_MAX = {1'b0, {mgr_pkg::TS_BITS{1'b1}}};

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [mgr_pkg::TS_BITS-1:0]   i_source_timestamp = '0;
    logic                          i_restart = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [mgr_pkg::RATE_BITS-1:0] o_rate_millihz;
    logic                          o_rate_valid;
    logic [mgr_pkg::MED_BITS-1:0]  o_median_gap_twice;

    int   fail_count;
    int   pending;
    int   results_checked;
    int   full_window_results;
    int   items_sent = 0;
    int   restarts_sent = 0;
    int   idle_cycles = 0;
    logic steady = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    median_gap_rate_estimator DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_source_timestamp (i_source_timestamp),
        .i_restart          (i_restart),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_rate_millihz     (o_rate_millihz),
        .o_rate_valid       (o_rate_valid),
        .o_median_gap_twice (o_median_gap_twice)
    );

    mgr_rate_checker checker_inst (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .i_in_ready            (o_in_ready),
        .i_source_timestamp    (i_source_timestamp),
        .i_restart             (i_restart),
        .i_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .i_rate_millihz        (o_rate_millihz),
        .i_rate_valid          (o_rate_valid),
        .i_median_gap_twice    (o_median_gap_twice),
        .o_fail_count          (fail_count),
        .o_pending             (pending),
        .o_results_checked     (results_checked),
        .o_full_window_results (full_window_results)
    );

    // Receiver stalls at random except during the steady stretch.
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 18);
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results still expected",
                     $time, IDLE_LIMIT, pending);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one timestamp after an optional random gap and waits for its transfer.
    task automatic send_timestamp(input logic [63:0] ts, input logic restart);
        if (!steady) begin
            while ($urandom_range(99) < 18) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_source_timestamp <= ts[mgr_pkg::TS_BITS-1:0];
        i_restart <= restart;
        items_sent++;
        if (restart) restarts_sent++;
        steady <= (items_sent >= 250 && items_sent < 370);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] cur;
        logic [63:0] gap;
        logic [63:0] prev_gap;
        logic [63:0] period;
        logic [63:0] jitter;
        logic [63:0] back;
        int          seq_len;
        int          pick;
        int          total;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty history, smallest gap, non-positive gaps, a gap
        // of exactly the ring maximum, oversized gaps and the timestamp extremes.
        send_timestamp(64'd0, 1'b0);
        send_timestamp(64'd1000, 1'b0);
        send_timestamp(64'd1001, 1'b0);
        send_timestamp(64'd1001, 1'b0);
        send_timestamp(64'd500, 1'b0);
        send_timestamp(64'd500 + 64'(mgr_pkg::GAP_MAX), 1'b0);
        send_timestamp(64'd500 + 64'(mgr_pkg::GAP_MAX) + 64'h100_0000_0000, 1'b0);
        send_timestamp(64'd500 + 64'(mgr_pkg::GAP_MAX) + 64'h100_0098_9680, 1'b0);
        send_timestamp(TS_MAX, 1'b1);
        send_timestamp(TS_MAX, 1'b0);
        send_timestamp(64'd0, 1'b0);
        send_timestamp(64'd5, 1'b0);
        send_timestamp(64'd16_666_672, 1'b0);
        send_timestamp(64'd33_333_339, 1'b0);
        send_timestamp(64'd50_000_006, 1'b0);
        send_timestamp(64'd60_000_000, 1'b1);
        send_timestamp(64'd0, 1'b1);
        send_timestamp(64'h4000_0000_0000_0000, 1'b0);
        send_timestamp(64'h4000_0000_01FC_A055, 1'b0);
        send_timestamp(TS_MAX, 1'b0);
        send_timestamp(TS_MAX - 1, 1'b0);

        // Random part: restarted streams at a nominal period with jitter, mixed
        // with short, repeated and oversized gaps, steps back and stray restarts.
        total = items_sent + RANDOM_ITEMS;
        prev_gap = 64'd1;
        while (items_sent < total) begin
            cur = ($urandom_range(9) < 3) ? 64'($urandom_range(1, 1_000_000))
                                          : {$urandom, $urandom} & TS_MAX;
            send_timestamp(cur, 1'b1);
            period = 64'($urandom_range(2_000_000, 50_000_000));
            jitter = ($urandom_range(3) == 0) ? 64'd0 : period / 8;
            seq_len = $urandom_range(20, 80);
            for (int k = 0; k < seq_len && items_sent < total; k++) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    gap = period - jitter + 64'($urandom_range(0, int'(2 * jitter)));
                end else if (pick < 78) begin
                    gap = 64'($urandom_range(1, 1000));
                end else if (pick < 84) begin
                    gap = ($urandom_range(1) == 0)
                        ? 64'(mgr_pkg::GAP_MAX) - 1 + 64'($urandom_range(0, 2))
                        : 64'h1_0000_0000 + ({$urandom, $urandom} & 64'hFF_FFFF_FFFF);
                end else if (pick < 90) begin
                    gap = prev_gap;
                end else begin
                    gap = 64'd0;
                end
                if (pick >= 97) begin
                    // A restart in the middle of a stream.
                    cur = {$urandom, $urandom} & TS_MAX;
                    send_timestamp(cur, 1'b1);
                end else if (pick >= 90) begin
                    // Step back or repeat: the gap is not positive.
                    back = 64'($urandom_range(0, 1000));
                    cur = (cur >= back) ? cur - back : 64'd0;
                    send_timestamp(cur, 1'b0);
                end else if (cur + gap > TS_MAX) begin
                    cur = 64'($urandom_range(1, 1000));
                    send_timestamp(cur, 1'b1);
                end else begin
                    cur = cur + gap;
                    prev_gap = gap;
                    send_timestamp(cur, 1'b0);
                end
            end
        end
        i_in_valid <= 1'b0;

        // Drain: wait for every expected result, then let the block settle.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d timestamps (%0d restarts); compared %0d results,",
                 items_sent, restarts_sent, results_checked);
        $display("%0d of them with a full window.", full_window_results);
        if (pending != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
